>>> hw/rtl/pva_pkg.sv
package pva_pkg;

  localparam int VOICES_DEF = 8;
  localparam int VOICES_MAX = 32;
  localparam int MAX_RES    = 8;
  localparam int TICK_W     = 32;
  localparam int NOTE_W     = 7;

  // Input operation codes
  localparam logic [2:0] OP_NOTE_ON    = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF   = 3'd1;
  localparam logic [2:0] OP_VOICE_DONE = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_ALL_OFF    = 3'd4;

  // Result action codes
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_NOTHING = 2'd2;

  // Register indexes
  localparam logic REG_UNISON = 1'b0;

  // State of one voice, as held in one cell of the ring.
  typedef struct packed {
    logic [NOTE_W-1:0] pitch;
    logic              held;
    logic              sounding;
    logic [TICK_W-1:0] start;
  } voice_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]        voice;
    logic [1:0]        action;
    logic [NOTE_W-1:0] pitch;
    logic [2:0]        slot;
  } result_t;

endpackage

>>> hw/rtl/pva_cell.sv
module pva_cell
  import pva_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_en_i,
  input  voice_t d_i,
  output voice_t q_o
);

  voice_t voice_q, voice_d;

  // The cell takes its neighbour's voice whenever the ring advances.
  assign voice_d = shift_en_i ? d_i : voice_q;
  assign q_o     = voice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else begin
      voice_q <= voice_d;
    end
  end

endmodule

>>> hw/rtl/pva_ctrl.sv
module pva_ctrl
  import pva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        unison_i,
  // ring access: head cell in, modified voice out to the tail cell
  input  voice_t      head_i,
  output voice_t      tail_o,
  output logic        shift_en_o,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] note, [9:7] voice_id, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] op
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] voice, [9:3] pitch, [12:10] detune_slot
  output logic [1:0]  m_tuser,   // [1:0] action
  output logic        m_tlast
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(MAX_RES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_APPLY  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [NOTE_W-1:0] note_q, note_d;
  logic [2:0]        vid_q, vid_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TICK_W-1:0] tick_q, tick_d;

  logic              match_found_q, match_found_d;
  logic [IW-1:0]     match_idx_q, match_idx_d;
  logic              free_found_q, free_found_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic              best_held_q, best_held_d;
  logic [TICK_W-1:0] best_start_q, best_start_d;

  logic              pend_valid_q, pend_valid_d;
  result_t           pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d;

  logic              accept;
  logic              idx_last;
  logic [IW+2:0]     idx_ext;
  logic [IW-1:0]     pick_idx;
  logic              hit;
  logic              report;
  logic              push;
  logic              out_free;
  logic              step_ok;
  result_t           res;
  voice_t            tail;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state_q == ST_IDLE);
  assign idx_last = (idx_q == IW'(VOICES - 1));
  assign idx_ext  = {3'b000, idx_q};
  assign pick_idx = match_found_q ? match_idx_q :
                    free_found_q  ? free_idx_q  : best_idx_q;
  assign out_free = !out_valid_q || m_tready;

  // Effect of the current operation on the voice at the head of the ring.
  always_comb begin
    tail       = head_i;
    hit        = 1'b0;
    res        = '0;
    res.voice  = idx_ext[2:0];
    if (state_q == ST_APPLY) begin
      case (op_q)
        OP_NOTE_ON: begin
          if (unison_i || (idx_q == pick_idx)) begin
            tail.pitch    = note_q;
            tail.held     = 1'b1;
            tail.sounding = 1'b1;
            tail.start    = tick_q;
            hit           = 1'b1;
            res.action    = ACT_START;
            res.pitch     = note_q;
            res.slot      = unison_i ? idx_ext[2:0] : 3'd0;
          end
        end
        OP_NOTE_OFF: begin
          if (head_i.held && (head_i.pitch == note_q)) begin
            tail.held  = 1'b0;
            hit        = 1'b1;
            res.action = ACT_RELEASE;
            res.pitch  = head_i.pitch;
          end
        end
        OP_VOICE_DONE: begin
          if ({{IW{1'b0}}, vid_q} == idx_ext) begin
            tail.held     = 1'b0;
            tail.sounding = 1'b0;
          end
        end
        OP_ALL_OFF: begin
          if (head_i.sounding) begin
            tail.held  = 1'b0;
            hit        = 1'b1;
            res.action = ACT_RELEASE;
            res.pitch  = head_i.pitch;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Only the first MAX_RES results of an item are reported; the staged
  // result moves to the output once a newer one shows it is not the last.
  assign report     = hit && (cnt_q < CW'(MAX_RES));
  assign push       = report && pend_valid_q;
  assign step_ok    = !push || out_free;
  assign shift_en_o = (state_q == ST_SCAN) || ((state_q == ST_APPLY) && step_ok);
  assign tail_o     = tail;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    note_d        = note_q;
    vid_d         = vid_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    tick_d        = tick_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    best_idx_d    = best_idx_q;
    best_held_d   = best_held_q;
    best_start_d  = best_start_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    out_last_d    = out_last_q;

    if (out_valid_q && m_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d          = s_tuser;
          note_d        = s_tdata[6:0];
          vid_d         = s_tdata[9:7];
          idx_d         = '0;
          cnt_d         = '0;
          pend_valid_d  = 1'b0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
          if ((s_tuser == OP_NOTE_ON) && !unison_i) begin
            state_d = ST_SCAN;
          end else if (s_tuser inside {OP_NOTE_ON, OP_NOTE_OFF, OP_VOICE_DONE,
                                       OP_ALL_OFF}) begin
            state_d = ST_APPLY;
          end else begin
            if (s_tuser == OP_TICK) begin
              tick_d = tick_q + TICK_W'(1);
            end
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (!match_found_q && head_i.sounding && (head_i.pitch == note_q)) begin
          match_found_d = 1'b1;
          match_idx_d   = idx_q;
        end
        if (!free_found_q && !head_i.sounding) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if ((idx_q == '0) ||
            (!head_i.held && best_held_q) ||
            ((head_i.held == best_held_q) && (head_i.start < best_start_q))) begin
          best_idx_d   = idx_q;
          best_held_d  = head_i.held;
          best_start_d = head_i.start;
        end
        idx_d = idx_last ? '0 : idx_q + IW'(1);
        if (idx_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (step_ok) begin
          if (push) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_last_d  = 1'b0;
          end
          if (report) begin
            pend_valid_d = 1'b1;
            pend_d       = res;
            cnt_d        = cnt_q + CW'(1);
          end
          idx_d = idx_last ? '0 : idx_q + IW'(1);
          if (idx_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (pend_valid_q) begin
            out_d = pend_q;
          end else begin
            out_d        = '0;
            out_d.action = ACT_NOTHING;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      tick_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      tick_q       <= tick_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    note_q        <= note_d;
    vid_q         <= vid_d;
    match_found_q <= match_found_d;
    match_idx_q   <= match_idx_d;
    free_found_q  <= free_found_d;
    free_idx_q    <= free_idx_d;
    best_idx_q    <= best_idx_d;
    best_held_q   <= best_held_d;
    best_start_q  <= best_start_d;
    pend_q        <= pend_d;
    out_q         <= out_d;
    out_last_q    <= out_last_d;
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {3'b000, out_q.slot, out_q.pitch, out_q.voice};
  assign m_tuser  = out_q.action;
  assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_nothing_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && (m_tuser == ACT_NOTHING)) |-> m_tlast)
    else $error("nothing result without tlast");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RES))
    else $error("result count above limit");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && out_free) |=> (m_tvalid && m_tlast && s_tready))
    else $error("finish did not emit final result");

  a_scan_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (shift_en_o && !hit))
    else $error("ring stalled or modified during scan");
`endif

endmodule

>>> hw/rtl/poly_voice_allocator.sv
// One input transaction is handled at a time: a new one is taken only once the final
// result of the last has been issued. A note-on outside unison mode takes a scan pass,
// then an update pass. Other voice ops take only an update pass; ticks and unused codes none.
// The ring advances one cell per cycle in a pass, unless a stalled output holds an update pass.
// Reset (rst_ni, asynchronous, active low) clears every voice, the tick counter,
// unison_mode and all handshake state.
module poly_voice_allocator
  import pva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] note, [9:7] voice_id, [15:10] zero
  input  logic [2:0]  s_tuser,   // [2:0] op
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] voice, [9:3] pitch, [12:10] detune_slot, [15:13] zero
  output logic [1:0]  m_tuser,   // [1:0] action
  output logic        m_tlast
);

  // The single register, unison_mode, sits at byte address 0. Writes complete
  // in the access phase; pready is tied high so there are no wait states.
  logic   unison_q, unison_d;
  logic   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign unison_d = (cfg_wr && (paddr[2] == REG_UNISON)) ? pwdata[0] : unison_q;
  assign prdata   = (paddr[2] == REG_UNISON) ? {31'd0, unison_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unison_q <= 1'b0;
    end else begin
      unison_q <= unison_d;
    end
  end

  // The voices form a ring of cells. When the ring advances, each cell takes
  // the voice of its upper neighbour and the top cell takes the head voice as
  // the controller has updated it, so after VOICES steps every voice is back
  // in its own cell and has passed the head once, in index order.
  voice_t chain   [VOICES];
  voice_t tail;
  logic   shift_en;

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    voice_t cell_d;
    if (g == VOICES - 1) begin : g_top
      assign cell_d = tail;
    end else begin : g_mid
      assign cell_d = chain[g+1];
    end
    pva_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en),
      .d_i        (cell_d),
      .q_o        (chain[g])
    );
  end

  // The controller sequences the scan and update passes, keeps the tick
  // counter and stages results so that tlast marks the final one of each item.
  pva_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .unison_i   (unison_q),
    .head_i     (chain[0]),
    .tail_o     (tail),
    .shift_en_o (shift_en),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

>>> bench/tb_poly_voice_allocator.sv
module tb_poly_voice_allocator;
  import pva_pkg::*;

  // The block is built with its default voice count, and the bench mirrors it.
  localparam int N_VOICES = VOICES_DEF;

  // Operation codes above all-notes-off have no meaning and must leave the table alone.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // The unison register sits at byte address 4 * index.
  localparam logic [2:0] UNISON_ADDR = {REG_UNISON, 2'b00};

  // Longest gap from an accepted input transaction to its final result, with some margin.
  // The bench waits this long before a register write, once nothing is outstanding.
  localparam int DRAIN_CYCLES = 2 * N_VOICES + 8;

  // One expected result transaction, with the end-of-burst flag that travels on tlast.
  typedef struct packed {
    logic [2:0]        voice;
    logic [1:0]        action;
    logic [NOTE_W-1:0] pitch;
    logic [2:0]        slot;
    logic              is_last;
  } voice_result_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // [6:0] note, [9:7] voice_id, [15:10] zero
  logic [2:0]  s_tuser  = '0;  // [2:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [2:0] voice, [9:3] pitch, [12:10] detune_slot, [15:13] zero
  logic [1:0]  m_tuser;        // [1:0] action
  logic        m_tlast;

  poly_voice_allocator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Percentage of cycles in which the sender holds back, and in which the
  // receiver refuses a result. Both are changed between phases of the run.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;

  // The bench's own copy of the voice table, tick counter and unison setting.
  logic [NOTE_W-1:0] v_pitch    [N_VOICES];
  logic              v_held     [N_VOICES];
  logic              v_sounding [N_VOICES];
  logic [TICK_W-1:0] v_start    [N_VOICES];
  logic [TICK_W-1:0] tick_ctr;
  logic              unison_q;

  // Results worked out for accepted input transactions, oldest first.
  voice_result_t pending_results [$];

  initial begin
    for (int i = 0; i < N_VOICES; i++) begin
      v_pitch[i]    = '0;
      v_held[i]     = 1'b0;
      v_sounding[i] = 1'b0;
      v_start[i]    = '0;
    end
    tick_ctr = '0;
    unison_q = 1'b0;
  end

  // A voice that starts takes the note, opens its gate and is stamped with the current tick.
  function automatic void sound_voice(input int idx, input logic [NOTE_W-1:0] note);
    v_pitch[idx]    = note;
    v_held[idx]     = 1'b1;
    v_sounding[idx] = 1'b1;
    v_start[idx]    = tick_ctr;
  endfunction

  // Applies one input transaction to the voice table and queues the results it causes.
  function automatic void allocate_voices(input logic [2:0] op, input logic [NOTE_W-1:0] note,
                                          input logic [2:0] vid);
    voice_result_t res [MAX_RES];
    int            n;
    int            pick;
    logic          best_held;
    n    = 0;
    pick = -1;
    case (op)
      OP_NOTE_ON: begin
        if (unison_q) begin
          // Every voice is stacked on the note, each with its own detune slot.
          for (int i = 0; i < N_VOICES; i++) begin
            sound_voice(i, note);
            res[n] = '{3'(i), ACT_START, note, 3'(i), 1'b0};
            n++;
          end
        end else begin
          // Scanning downwards leaves the lowest matching index in pick.
          for (int i = N_VOICES - 1; i >= 0; i--) begin
            if (v_sounding[i] && v_pitch[i] == note) pick = i;
          end
          if (pick < 0) begin
            for (int i = N_VOICES - 1; i >= 0; i--) begin
              if (!v_sounding[i]) pick = i;
            end
          end
          if (pick < 0) begin
            // Steal the oldest voice, a released one before any held one.
            pick      = 0;
            best_held = v_held[0];
            for (int i = 1; i < N_VOICES; i++) begin
              if ((!v_held[i] && best_held) ||
                  (v_held[i] == best_held && v_start[i] < v_start[pick])) begin
                pick      = i;
                best_held = v_held[i];
              end
            end
          end
          sound_voice(pick, note);
          res[n] = '{3'(pick), ACT_START, note, 3'd0, 1'b0};
          n++;
        end
      end
      OP_NOTE_OFF: begin
        for (int i = 0; i < N_VOICES; i++) begin
          if (v_held[i] && v_pitch[i] == note) begin
            v_held[i] = 1'b0;
            res[n] = '{3'(i), ACT_RELEASE, v_pitch[i], 3'd0, 1'b0};
            n++;
          end
        end
      end
      OP_VOICE_DONE: begin
        v_sounding[vid] = 1'b0;
        v_held[vid]     = 1'b0;
      end
      OP_TICK: begin
        tick_ctr = tick_ctr + TICK_W'(1);
      end
      OP_ALL_OFF: begin
        // Released voices that still sound are reported too.
        for (int i = 0; i < N_VOICES; i++) begin
          if (v_sounding[i]) begin
            v_held[i] = 1'b0;
            res[n] = '{3'(i), ACT_RELEASE, v_pitch[i], 3'd0, 1'b0};
            n++;
          end
        end
      end
      default: ;
    endcase
    // An input that touches no voice still answers with a single empty result.
    if (n == 0) begin
      res[0] = '{3'd0, ACT_NOTHING, 7'd0, 3'd0, 1'b0};
      n = 1;
    end
    res[n-1].is_last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endfunction

  // The receiver refuses results at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each accepted result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    voice_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: voice %0d action %0d pitch %0d slot %0d last %0b",
               m_tdata[2:0], m_tuser, m_tdata[9:3], m_tdata[12:10], m_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[2:0] !== want.voice) begin
          $error("voice: expected %0d, got %0d", want.voice, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tuser !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, m_tuser);
          mismatches++;
        end
        if (m_tdata[9:3] !== want.pitch) begin
          $error("pitch: expected %0d, got %0d", want.pitch, m_tdata[9:3]);
          mismatches++;
        end
        if (m_tdata[12:10] !== want.slot) begin
          $error("detune_slot: expected %0d, got %0d", want.slot, m_tdata[12:10]);
          mismatches++;
        end
        if (m_tlast !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // Offers one input transaction, after a random hold-off, and predicts its results
  // once it has been taken. tvalid is left high so that a following transaction can
  // go out back to back; whoever comes next lowers it if need be.
  task automatic play_event(input logic [2:0] op, input logic [NOTE_W-1:0] note,
                            input logic [2:0] vid);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, vid, note};
    do @(posedge clk_i); while (!s_tready);
    allocate_voices(op, note, vid);
  endtask

  // Stops sending and waits until every expected result has come and the block is at rest.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // A setup phase then an access phase; the register takes the value at the end of access.
  task automatic write_unison(input logic value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= UNISON_ADDR;
    pwdata  <= {31'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    unison_q  = value;
  endtask

  // Single-voice allocation: empty answers, unknown codes, note reuse, the silent
  // voice search, stealing with a released voice preferred, and release of all voices.
  task automatic test_poly_allocation();
    play_event(OP_TICK, 7'd0, 3'd0);
    play_event(OP_NOTE_OFF, 7'd5, 3'd0);        // nothing held yet
    play_event(OP_ALL_OFF, 7'd0, 3'd0);         // nothing sounding yet
    play_event(OP_VOICE_DONE, 7'd0, 3'd7);
    play_event(OP_UNUSED_LO, 7'd127, 3'd7);
    play_event(OP_UNUSED_LO + 3'd1, 7'd127, 3'd7);
    play_event(OP_UNUSED_HI, 7'd127, 3'd7);
    play_event(OP_NOTE_ON, 7'd0, 3'd0);
    play_event(OP_NOTE_ON, 7'd127, 3'd0);
    play_event(OP_NOTE_ON, 7'd127, 3'd0);       // same note again reuses its voice
    play_event(OP_NOTE_OFF, 7'd127, 3'd0);      // leaves that voice released but sounding
    play_event(OP_TICK, 7'd0, 3'd0);
    for (int k = 1; k <= 6; k++) play_event(OP_NOTE_ON, 7'(k), 3'd0);
    play_event(OP_NOTE_ON, 7'd100, 3'd0);       // table full: the released voice is stolen
    play_event(OP_ALL_OFF, 7'd0, 3'd0);
    play_event(OP_VOICE_DONE, 7'd0, 3'd0);
    play_event(OP_NOTE_ON, 7'd50, 3'd0);        // takes the voice just silenced
  endtask

  // Unison: one note-on starts every voice with its own detune slot, and a note-off
  // releases the whole stack.
  task automatic test_unison_stack();
    drain_results();
    write_unison(1'b1);
    play_event(OP_NOTE_ON, 7'd64, 3'd0);
    play_event(OP_NOTE_OFF, 7'd64, 3'd0);
    drain_results();
    write_unison(1'b0);
  endtask

  // Random traffic. Most notes come from the narrow range 60 to 67 so that reuse, note-off matches
  // and stealing happen often; the rest cover the full note range.
  task automatic test_random_traffic(input int count);
    int unsigned       pick_op;
    logic [2:0]        op;
    logic [NOTE_W-1:0] note;
    for (int k = 0; k < count; k++) begin
      pick_op = $urandom_range(99);
      if (pick_op < 36)      op = OP_NOTE_ON;
      else if (pick_op < 56) op = OP_NOTE_OFF;
      else if (pick_op < 71) op = OP_VOICE_DONE;
      else if (pick_op < 86) op = OP_TICK;
      else if (pick_op < 95) op = OP_ALL_OFF;
      else                   op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      if ($urandom_range(99) < 80) note = 7'($urandom_range(67, 60));
      else                         note = 7'($urandom_range(127, 0));
      play_event(op, note, 3'($urandom_range(7)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 73;
    test_poly_allocation();
    test_unison_stack();

    // Three idling regimes; in each the unison setting changes once, with the
    // block drained before every write.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 16; recv_idle_pct = 73; end
        1:       begin send_idle_pct = 73; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int half = 0; half < 2; half++) begin
        drain_results();
        write_unison(1'(half) ^ 1'(phase));
        test_random_traffic(23);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // A run that hangs on a handshake ends here.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
